// ----- rtl/core/sag_pkg.sv -----
// sag_pkg: item types and ray-mask functions for the sliding attack generator.
// No dependencies; used by sag_ray_resolve and sliding_attack_generator.
package sag_pkg;

  localparam int unsigned BoardBits  = 64;
  localparam int unsigned SquareBits = 6;
  localparam int unsigned NumRays    = 4;

  typedef logic [BoardBits-1:0] board_t;

  typedef struct packed {
    logic                  mode;
    logic [SquareBits-1:0] origin_square;
    board_t                occupied_map;
  } sag_in_t;

  typedef struct packed {
    board_t attack_map;
    board_t blocker_mask;
  } sag_out_t;

  // ray from sq in direction (dr, df), origin excluded; lo/hi bound the moving coordinate
  function automatic board_t ray_mask(logic [SquareBits-1:0] sq, int dr, int df,
                                      int lo, int hi);
    board_t acc;
    int     rank;
    int     file;
    int     r;
    int     f;
    acc  = '0;
    rank = int'(sq[5:3]);
    file = int'(sq[2:0]);
    for (int k = 1; k < 8; k++) begin
      r = rank + k * dr;
      f = file + k * df;
      if (r >= 0 && r <= 7 && f >= 0 && f <= 7 &&
          (dr == 0 || (r >= lo && r <= hi)) &&
          (df == 0 || (f >= lo && f <= hi))) begin
        acc[6'(r * 8 + f)] = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic board_t rev_board(board_t x);
    board_t y;
    for (int i = 0; i < BoardBits; i++) begin
      y[i] = x[BoardBits-1-i];
    end
    return y;
  endfunction

endpackage

// ----- rtl/core/sliding_attack_generator.sv -----
// sliding_attack_generator: rook/bishop attack map and relevant blocker mask.
// Depends on sag_pkg and sag_ray_resolve.
// One item per cycle; busy stays low.
// Stages: ray decode, lowest-blocker isolate, ray cut and merge.
// Synchronous active-low reset clears the stage valid bits; nothing else is held.
module sliding_attack_generator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sag_pkg::sag_in_t  in_item,
  output logic              out_valid,
  output sag_pkg::sag_out_t out_item
);

  logic                        v1_r;
  logic                        v2_r;
  logic                        out_valid_r;
  logic                        take;
  sag_pkg::board_t             ray_nxt  [sag_pkg::NumRays];
  sag_pkg::board_t             ray_r    [sag_pkg::NumRays];
  sag_pkg::board_t             hits_r   [sag_pkg::NumRays];
  sag_pkg::board_t             att      [sag_pkg::NumRays];
  sag_pkg::board_t             blk_nxt;
  sag_pkg::board_t             blk1_r;
  sag_pkg::board_t             blk2_r;
  sag_pkg::board_t             att_all;
  sag_pkg::sag_out_t           out_r;
  sag_pkg::sag_out_t           out_nxt;
  logic [sag_pkg::SquareBits-1:0] sq;

  assign busy = 1'b0;
  assign take = start && !busy;
  assign sq   = in_item.origin_square;

  // slots 0,1 run toward higher indexes; slots 2,3 run downward and are bit-reversed
  always_comb begin
    if (in_item.mode) begin
      ray_nxt[0] = sag_pkg::ray_mask(sq, 1, 1, 0, 7);
      ray_nxt[1] = sag_pkg::ray_mask(sq, 1, -1, 0, 7);
      ray_nxt[2] = sag_pkg::rev_board(sag_pkg::ray_mask(sq, -1, -1, 0, 7));
      ray_nxt[3] = sag_pkg::rev_board(sag_pkg::ray_mask(sq, -1, 1, 0, 7));
      blk_nxt    = sag_pkg::ray_mask(sq, 1, 1, 1, 6) | sag_pkg::ray_mask(sq, 1, -1, 1, 6) |
                   sag_pkg::ray_mask(sq, -1, -1, 1, 6) | sag_pkg::ray_mask(sq, -1, 1, 1, 6);
    end else begin
      ray_nxt[0] = sag_pkg::ray_mask(sq, 1, 0, 0, 7);
      ray_nxt[1] = sag_pkg::ray_mask(sq, 0, 1, 0, 7);
      ray_nxt[2] = sag_pkg::rev_board(sag_pkg::ray_mask(sq, -1, 0, 0, 7));
      ray_nxt[3] = sag_pkg::rev_board(sag_pkg::ray_mask(sq, 0, -1, 0, 7));
      blk_nxt    = sag_pkg::ray_mask(sq, 1, 0, 1, 6) | sag_pkg::ray_mask(sq, 0, 1, 1, 6) |
                   sag_pkg::ray_mask(sq, -1, 0, 1, 6) | sag_pkg::ray_mask(sq, 0, -1, 1, 6);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= take;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 2; i++) begin
        ray_r[i]  <= ray_nxt[i];
        hits_r[i] <= ray_nxt[i] & in_item.occupied_map;
      end
      for (int i = 2; i < sag_pkg::NumRays; i++) begin
        ray_r[i]  <= ray_nxt[i];
        hits_r[i] <= ray_nxt[i] & sag_pkg::rev_board(in_item.occupied_map);
      end
      blk1_r <= blk_nxt;
    end
    if (v1_r) begin
      blk2_r <= blk1_r;
    end
    if (v2_r) begin
      out_r <= out_nxt;
    end
  end

  for (genvar g = 0; g < sag_pkg::NumRays; g++) begin : g_ray
    sag_ray_resolve u_resolve (
      .clk    (clk),
      .en     (v1_r),
      .ray    (ray_r[g]),
      .hits   (hits_r[g]),
      .attack (att[g])
    );
  end

  assign att_all = att[0] | att[1] | sag_pkg::rev_board(att[2]) | sag_pkg::rev_board(att[3]);

  always_comb begin
    out_nxt.attack_map   = att_all;
    out_nxt.blocker_mask = blk2_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, 3))
    else $error("result without a matching item");

  a_attack_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.attack_map != '0)
    else $error("empty attack map");

  a_blocker_no_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.blocker_mask & 64'h8100_0000_0000_0081) == '0)
    else $error("corner square in blocker mask");

endmodule

// ----- rtl/core/sag_ray_resolve.sv -----
// sag_ray_resolve: cuts one upward ray at its lowest blocker (blocker kept).
// Depends on sag_pkg. One register stage; result is formed from those registers.
module sag_ray_resolve (
  input  logic            clk,
  input  logic            en,
  input  sag_pkg::board_t ray,
  input  sag_pkg::board_t hits,
  output sag_pkg::board_t attack
);

  sag_pkg::board_t ray_r;
  sag_pkg::board_t lsb_r;
  sag_pkg::board_t lsb_nxt;

  assign lsb_nxt = hits & (~hits + sag_pkg::board_t'(1));

  always_ff @(posedge clk) begin
    if (en) begin
      ray_r <= ray;
      lsb_r <= lsb_nxt;
    end
  end

  // no blocker: lsb is zero and the mask becomes all ones
  assign attack = ray_r & (lsb_r ^ (lsb_r - sag_pkg::board_t'(1)));

endmodule

// ----- tb/sliding_attack_generator_tb.sv -----
// Self-checking testbench for sliding_attack_generator: directed table, then shaped random items.
// Depends on sag_pkg and the sliding_attack_generator RTL; expected maps: table or ray walker.
module sliding_attack_generator_tb;

  typedef struct {
    sag_pkg::sag_in_t  stim;
    bit                typed;
    sag_pkg::sag_out_t want;
  } probe_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  sag_pkg::sag_in_t  in_item;
  logic              out_valid;
  sag_pkg::sag_out_t out_item;

  sag_pkg::sag_out_t pending_maps[$];
  sag_pkg::sag_out_t next_map;
  probe_row_t        probes[$];
  int                errors;

  sliding_attack_generator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // walk each ray to the board edge; attacks stop after the first blocker,
  // the mask drops the last square of each ray
  function automatic sag_pkg::sag_out_t slide_rays(sag_pkg::sag_in_t it);
    sag_pkg::sag_out_t res;
    int                dr[4];
    int                df[4];
    int                r;
    int                f;
    bit                blocked;
    res = '0;
    if (it.mode) begin
      dr = '{1, 1, -1, -1};
      df = '{1, -1, 1, -1};
    end else begin
      dr = '{1, -1, 0, 0};
      df = '{0, 0, 1, -1};
    end
    for (int d = 0; d < 4; d++) begin
      r       = int'(it.origin_square[5:3]) + dr[d];
      f       = int'(it.origin_square[2:0]) + df[d];
      blocked = 1'b0;
      while (r >= 0 && r <= 7 && f >= 0 && f <= 7) begin
        if (!blocked) res.attack_map[r*8+f] = 1'b1;
        if (it.occupied_map[r*8+f]) blocked = 1'b1;
        if (r + dr[d] >= 0 && r + dr[d] <= 7 && f + df[d] >= 0 && f + df[d] <= 7) begin
          res.blocker_mask[r*8+f] = 1'b1;
        end
        r += dr[d];
        f += df[d];
      end
    end
    return res;
  endfunction

  // occupancy of varied density: uniform, sparse, dense, or a handful of pieces
  function automatic sag_pkg::sag_in_t random_item();
    sag_pkg::sag_in_t it;
    sag_pkg::board_t  occ;
    it.mode          = 1'($urandom_range(1));
    it.origin_square = 6'($urandom_range(63));
    case ($urandom_range(3))
      0: occ = {$urandom, $urandom};
      1: occ = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2: occ = {$urandom, $urandom} | {$urandom, $urandom};
      default: begin
        occ = '0;
        repeat ($urandom_range(4)) occ[$urandom_range(63)] = 1'b1;
      end
    endcase
    it.occupied_map = occ;
    return it;
  endfunction

  task automatic add_probe(bit mode, logic [5:0] sq, sag_pkg::board_t occ, bit typed,
                           sag_pkg::board_t atk, sag_pkg::board_t msk);
    probe_row_t row;
    row.stim.mode               = mode;
    row.stim.origin_square      = sq;
    row.stim.occupied_map       = occ;
    row.typed                   = typed;
    row.want.attack_map         = atk;
    row.want.blocker_mask       = msk;
    probes.push_back(row);
  endtask

  task automatic send_item(sag_pkg::sag_in_t it, bit typed, sag_pkg::sag_out_t want,
                           int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_item <= random_item();
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_maps.push_back(typed ? want : slide_rays(it));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_maps.size() == 0) begin
        $error("unexpected item: attack_map %h blocker_mask %h",
               out_item.attack_map, out_item.blocker_mask);
        errors++;
      end else begin
        next_map = pending_maps.pop_front();
        if (out_item.attack_map !== next_map.attack_map) begin
          $error("attack_map: expected %h, actual %h", next_map.attack_map, out_item.attack_map);
          errors++;
        end
        if (out_item.blocker_mask !== next_map.blocker_mask) begin
          $error("blocker_mask: expected %h, actual %h",
                 next_map.blocker_mask, out_item.blocker_mask);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int                idle_pcts[3];
    int                drain_cycles;
    sag_pkg::sag_out_t none;
    errors    = 0;
    none      = '0;
    idle_pcts = '{0, 58, 14};
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_item  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // corners on an empty or full board, edge blockers, origin occupied
    add_probe(0, 6'd0,  '0, 1, 64'h0101_0101_0101_01FE, 64'h0001_0101_0101_017E);
    add_probe(1, 6'd0,  '0, 1, 64'h8040_2010_0804_0200, 64'h0040_2010_0804_0200);
    add_probe(0, 6'd0,  '1, 1, 64'h0000_0000_0000_0102, 64'h0001_0101_0101_017E);
    add_probe(1, 6'd63, '1, 1, 64'h0040_0000_0000_0000, 64'h0040_2010_0804_0200);
    add_probe(0, 6'd63, '0, 1, 64'h7F80_8080_8080_8080, 64'h7E80_8080_8080_8000);
    add_probe(1, 6'd7,  '0, 1, 64'h0102_0408_1020_4000, 64'h0002_0408_1020_4000);
    add_probe(0, 6'd27, 64'h0000_0000_0800_0000, 0, none, none);
    add_probe(1, 6'd27, 64'h0000_0000_0800_0000, 0, none, none);
    add_probe(0, 6'd27, 64'hFF81_8181_8181_81FF, 0, none, none);
    add_probe(1, 6'd27, 64'hFF81_8181_8181_81FF, 0, none, none);
    add_probe(1, 6'd36, '1, 0, none, none);
    add_probe(0, 6'd36, '1, 0, none, none);
    add_probe(0, 6'd36, '0, 0, none, none);
    add_probe(1, 6'd36, '0, 0, none, none);
    add_probe(0, 6'd18, 64'hAAAA_AAAA_AAAA_AAAA, 0, none, none);
    add_probe(1, 6'd45, 64'h5555_5555_5555_5555, 0, none, none);
    add_probe(0, 6'd56, 64'hFEFF_FFFF_FFFF_FFFF, 0, none, none);
    add_probe(1, 6'd56, 64'hFEFF_FFFF_FFFF_FFFF, 0, none, none);
    add_probe(1, 6'd63, '0, 0, none, none);
    add_probe(0, 6'd7,  64'h8000_0000_0000_0080, 0, none, none);
    foreach (probes[i]) send_item(probes[i].stim, probes[i].typed, probes[i].want, 0);

    foreach (idle_pcts[p]) begin
      repeat (450) send_item(random_item(), 1'b0, none, idle_pcts[p]);
    end
    start <= 1'b0;

    drain_cycles = 0;
    while (pending_maps.size() != 0 && drain_cycles < 200) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (pending_maps.size() != 0) begin
      $error("%0d items never came out", pending_maps.size());
      errors++;
    end
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
